@@ rtl/dsgc_pkg.sv @@
// ============================================================================
// dsgc_pkg
// Types, codes and constants that the score group combiner files share.
// ============================================================================
`default_nettype none

package dsgc_pkg;

    // Default number of positions that one record holds.
    localparam int MAX_POS_DEF = 16;

    // Fixed field widths of the streams.
    localparam int DATA_W   = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int KIND_W   = 3;
    localparam int COUNT_W  = 5;
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 104;

    // Register reset values and counter ceiling.
    localparam logic [CFG_W-1:0] BASE_RST      = 16'd0;
    localparam logic [CFG_W-1:0] MAX_MERGE_RST = 16'd64;
    localparam logic [CFG_W-1:0] MAX_SEG_RST   = 16'd16;
    localparam logic [CFG_W-1:0] CNT_MAX       = 16'hFFFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_POSTINGS = 2'd0,
        CFG_MAX_MERGE     = 2'd1,
        CFG_MAX_SEGMENTS  = 2'd2
    } cfg_idx_t;

    // Input command codes.
    localparam logic CMD_EVENT  = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER   = 3'd0,
        KIND_POSITION = 3'd1,
        KIND_SEG_END  = 3'd2,
        KIND_STOP     = 3'd3,
        KIND_EMPTY    = 3'd4
    } kind_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_CHK_VISIT,
        ST_CHK_MERGE,
        ST_CHK_SEGS,
        ST_CHK_DOC,
        ST_FLUSH,
        ST_HEADER,
        ST_POSITION,
        ST_SEG_END,
        ST_STOP,
        ST_EMPTY,
        ST_UPDATE
    } state_t;

    // What a record flush returns to when it is done.
    typedef enum logic [1:0] {
        CTX_FINISH,
        CTX_SWITCH,
        CTX_TAIL
    } flush_ctx_t;

    // Result of the shared compare unit.
    typedef struct packed {
        logic eq;
        logic ge;
    } cmp_res_t;

endpackage : dsgc_pkg

`default_nettype wire

@@ rtl/dsgc_cmp.sv @@
// ============================================================================
// dsgc_cmp
// Shared unsigned compare unit that the sequencer uses in every check step.
// ============================================================================
`default_nettype none

module dsgc_cmp
    import dsgc_pkg::*;
(
    input  wire logic [DATA_W-1:0] op_a,
    input  wire logic [DATA_W-1:0] op_b,
    output cmp_res_t               res
);

    // Equality and unsigned greater-or-equal of the two operands.
    always_comb begin
        res.eq = (op_a == op_b);
        res.ge = (op_a >= op_b);
    end

endmodule : dsgc_cmp

`default_nettype wire

@@ rtl/doc_score_group_combiner.sv @@
// ============================================================================
// doc_score_group_combiner
// Groups scored match events per document and emits records per segment.
// ============================================================================
// Steps: an update-only event passes start, visit check, document check and
// update before ready returns; a filtered event goes from start to idle. A
// flush emits its results in turn through the single output register,
// waiting while it is full; every check step uses the one shared compare unit.
// Throughput: one item at a time; ready is high only while the sequencer idles.
// Reset: aresetn is synchronous and active low; control registers take defaults.
`default_nettype none

module doc_score_group_combiner
    import dsgc_pkg::*;
#(
    parameter int MAX_POS = MAX_POS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    // Input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // tdata: doc_id[31:0], score[63:32], position[95:64], dir_visit[127:96]
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    // tuser: cmd[0]
    input  wire logic [0:0]           s_tuser,
    // Result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // tdata: out_doc[31:0], out_score[63:32], match_count[68:64],
    //        out_position[100:69], zero fill[103:101]
    output logic [M_DATA_W-1:0]       m_tdata,
    // tuser: kind[2:0]
    output logic [KIND_W-1:0]         m_tuser,
    output logic                      m_tlast
);

    localparam int CW = $clog2(MAX_POS + 1);
    localparam int IW = (MAX_POS > 1) ? $clog2(MAX_POS) : 1;
    localparam logic [CW-1:0] POS_LIMIT = CW'(MAX_POS);

    // Configuration registers
    logic [CFG_W-1:0] base_reg;
    logic [CFG_W-1:0] max_merge_reg;
    logic [CFG_W-1:0] max_seg_reg;

    // Latched input item
    logic              cmd_reg;
    logic [DATA_W-1:0] doc_reg;
    logic [DATA_W-1:0] score_reg;
    logic [DATA_W-1:0] pos_reg;
    logic [DATA_W-1:0] visit_reg;

    // Expression and record state
    state_t            state_reg, state_next;
    flush_ctx_t        ctx_reg, ctx_next;
    logic              open_reg, open_next;
    logic [DATA_W-1:0] last_visit_reg, last_visit_next;
    logic [CFG_W-1:0]  seg_cnt_reg, seg_cnt_next;
    logic [CFG_W-1:0]  added_reg, added_next;
    logic [DATA_W-1:0] cur_doc_reg, cur_doc_next;
    logic [DATA_W-1:0] cur_score_reg, cur_score_next;
    logic [CW-1:0]     held_reg, held_next;
    logic [CW-1:0]     idx_reg, idx_next;

    logic [DATA_W-1:0] position_store [MAX_POS];

    // Output register
    logic               m_valid_reg;
    kind_t              m_kind_reg;
    logic               m_last_reg;
    logic [DATA_W-1:0]  m_doc_reg;
    logic [DATA_W-1:0]  m_score_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic [DATA_W-1:0]  m_pos_reg;

    // Sequencer outputs
    logic              emit_en;
    kind_t             emit_kind;
    logic              emit_last;
    logic              emit_rec;
    logic              emit_pos;
    logic              store_we;
    logic              flush_done;
    logic              out_free;
    logic              s_accept;
    logic [DATA_W-1:0] op_a;
    logic [DATA_W-1:0] op_b;
    cmp_res_t          cmp;
    logic [CW-1:0]     idx_inc;
    logic [DATA_W-1:0] held_wide;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign idx_inc   = idx_reg + CW'(1);
    assign held_wide = DATA_W'(held_reg);

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= BASE_RST;
            max_merge_reg <= MAX_MERGE_RST;
            max_seg_reg   <= MAX_SEG_RST;
        end else if (cfg_we) begin
            priority case (cfg_addr)
                CFG_BASE_POSTINGS: base_reg      <= cfg_wdata;
                CFG_MAX_MERGE:     max_merge_reg <= cfg_wdata;
                CFG_MAX_SEGMENTS:  max_seg_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Operand selection for the shared compare unit.
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_START: begin
                op_a = score_reg;
            end
            ST_CHK_VISIT: begin
                op_a = visit_reg;
                op_b = last_visit_reg;
            end
            ST_CHK_MERGE: begin
                op_a = DATA_W'(base_reg) + DATA_W'(added_reg) + DATA_W'(1);
                op_b = DATA_W'(max_merge_reg);
            end
            ST_CHK_SEGS: begin
                op_a = DATA_W'(seg_cnt_reg) + DATA_W'(1);
                op_b = DATA_W'(max_seg_reg);
            end
            ST_CHK_DOC: begin
                op_a = doc_reg;
                op_b = cur_doc_reg;
            end
            ST_FLUSH: begin
                op_a = cur_score_reg;
            end
            ST_UPDATE: begin
                op_a = cur_score_reg;
                op_b = score_reg;
            end
            default: ;
        endcase
    end

    dsgc_cmp u_cmp (
        .op_a (op_a),
        .op_b (op_b),
        .res  (cmp)
    );

    // Sequencer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ctx_reg        <= CTX_FINISH;
            open_reg       <= 1'b0;
            last_visit_reg <= '0;
            seg_cnt_reg    <= '0;
            added_reg      <= '0;
            cur_doc_reg    <= '0;
            cur_score_reg  <= '0;
            held_reg       <= '0;
            idx_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            ctx_reg        <= ctx_next;
            open_reg       <= open_next;
            last_visit_reg <= last_visit_next;
            seg_cnt_reg    <= seg_cnt_next;
            added_reg      <= added_next;
            cur_doc_reg    <= cur_doc_next;
            cur_score_reg  <= cur_score_next;
            held_reg       <= held_next;
            idx_reg        <= idx_next;
        end
    end

    // Input item capture on a transfer.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg   <= s_tuser[0];
            doc_reg   <= s_tdata[31:0];
            score_reg <= s_tdata[63:32];
            pos_reg   <= s_tdata[95:64];
            visit_reg <= s_tdata[127:96];
        end
    end

    // Next state and result generation.
    always_comb begin
        state_next      = state_reg;
        ctx_next        = ctx_reg;
        open_next       = open_reg;
        last_visit_next = last_visit_reg;
        seg_cnt_next    = seg_cnt_reg;
        added_next      = added_reg;
        cur_doc_next    = cur_doc_reg;
        cur_score_next  = cur_score_reg;
        held_next       = held_reg;
        idx_next        = idx_reg;
        emit_en         = 1'b0;
        emit_kind       = KIND_HEADER;
        emit_last       = 1'b0;
        emit_rec        = 1'b0;
        emit_pos        = 1'b0;
        store_we        = 1'b0;
        flush_done      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (cmd_reg == CMD_FINISH) begin
                    if (open_reg) begin
                        ctx_next   = CTX_FINISH;
                        state_next = ST_FLUSH;
                    end else begin
                        state_next = ST_EMPTY;
                    end
                end else if (cmp.eq) begin
                    // Zero score: the event is dropped.
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_CHK_VISIT;
                end
            end
            ST_CHK_VISIT: begin
                if (!open_reg || !cmp.eq) begin
                    state_next = ST_CHK_MERGE;
                end else begin
                    state_next = ST_CHK_DOC;
                end
            end
            ST_CHK_MERGE: begin
                state_next = cmp.ge ? ST_STOP : ST_CHK_SEGS;
            end
            ST_CHK_SEGS: begin
                if (cmp.ge) begin
                    state_next = ST_STOP;
                end else if (open_reg) begin
                    ctx_next   = CTX_SWITCH;
                    state_next = ST_FLUSH;
                end else begin
                    // Open the first segment of the expression.
                    cur_doc_next    = '0;
                    cur_score_next  = '0;
                    held_next       = '0;
                    open_next       = 1'b1;
                    last_visit_next = visit_reg;
                    if (seg_cnt_reg != CNT_MAX) begin
                        seg_cnt_next = seg_cnt_reg + CFG_W'(1);
                    end
                    state_next = ST_CHK_DOC;
                end
            end
            ST_CHK_DOC: begin
                if (!cmp.eq) begin
                    ctx_next   = CTX_TAIL;
                    state_next = ST_FLUSH;
                end else begin
                    state_next = ST_UPDATE;
                end
            end
            ST_FLUSH: begin
                // A record with zero score is not emitted.
                if (cmp.eq) begin
                    flush_done = 1'b1;
                end else begin
                    state_next = ST_HEADER;
                end
            end
            ST_HEADER: begin
                if (out_free) begin
                    emit_en   = 1'b1;
                    emit_kind = KIND_HEADER;
                    emit_rec  = 1'b1;
                    emit_last = (ctx_reg == CTX_TAIL) && (held_reg == '0);
                    idx_next  = '0;
                    if (held_reg == '0) begin
                        flush_done = 1'b1;
                    end else begin
                        state_next = ST_POSITION;
                    end
                end
            end
            ST_POSITION: begin
                if (out_free) begin
                    emit_en   = 1'b1;
                    emit_kind = KIND_POSITION;
                    emit_rec  = 1'b1;
                    emit_pos  = 1'b1;
                    emit_last = (ctx_reg == CTX_TAIL) && (idx_inc == held_reg);
                    idx_next  = idx_inc;
                    if (idx_inc == held_reg) begin
                        flush_done = 1'b1;
                    end
                end
            end
            ST_SEG_END: begin
                if (out_free) begin
                    emit_en   = 1'b1;
                    emit_kind = KIND_SEG_END;
                    emit_last = 1'b1;
                    if (ctx_reg == CTX_FINISH) begin
                        // Finish returns the expression state to its defaults.
                        open_next       = 1'b0;
                        last_visit_next = '0;
                        seg_cnt_next    = '0;
                        added_next      = '0;
                        cur_doc_next    = '0;
                        cur_score_next  = '0;
                        held_next       = '0;
                        state_next      = ST_IDLE;
                    end else begin
                        // Segment switch: count the posting and start afresh.
                        if (added_reg != CNT_MAX) begin
                            added_next = added_reg + CFG_W'(1);
                        end
                        if (seg_cnt_reg != CNT_MAX) begin
                            seg_cnt_next = seg_cnt_reg + CFG_W'(1);
                        end
                        cur_doc_next    = '0;
                        cur_score_next  = '0;
                        held_next       = '0;
                        last_visit_next = visit_reg;
                        state_next      = ST_CHK_DOC;
                    end
                end
            end
            ST_STOP: begin
                if (out_free) begin
                    emit_en    = 1'b1;
                    emit_kind  = KIND_STOP;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    emit_en         = 1'b1;
                    emit_kind       = KIND_EMPTY;
                    emit_last       = 1'b1;
                    open_next       = 1'b0;
                    last_visit_next = '0;
                    seg_cnt_next    = '0;
                    added_next      = '0;
                    cur_doc_next    = '0;
                    cur_score_next  = '0;
                    held_next       = '0;
                    state_next      = ST_IDLE;
                end
            end
            ST_UPDATE: begin
                // Keep the highest score and store the position if room is left.
                if (!cmp.ge) begin
                    cur_score_next = score_reg;
                end
                if (held_reg < POS_LIMIT) begin
                    store_we  = 1'b1;
                    held_next = held_reg + CW'(1);
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Where a flush continues once its record is out.
        if (flush_done) begin
            unique case (ctx_reg)
                CTX_FINISH, CTX_SWITCH: begin
                    state_next = ST_SEG_END;
                end
                CTX_TAIL: begin
                    cur_doc_next   = doc_reg;
                    cur_score_next = '0;
                    held_next      = '0;
                    state_next     = ST_UPDATE;
                end
                default: begin
                    state_next = ST_SEG_END;
                end
            endcase
        end
    end

    // Position store: written by an update, read while a record goes out.
    always_ff @(posedge aclk) begin
        if (store_we) begin
            position_store[held_reg[IW-1:0]] <= pos_reg;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload; unused fields are zero.
    always_ff @(posedge aclk) begin
        if (emit_en) begin
            m_kind_reg  <= emit_kind;
            m_last_reg  <= emit_last;
            m_doc_reg   <= emit_rec ? cur_doc_reg : '0;
            m_score_reg <= emit_rec ? cur_score_reg : '0;
            m_count_reg <= emit_rec ? held_wide[COUNT_W-1:0] : '0;
            m_pos_reg   <= emit_pos ? position_store[idx_reg[IW-1:0]] : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_pos_reg, m_count_reg, m_score_reg, m_doc_reg};

endmodule : doc_score_group_combiner

`default_nettype wire
